// ===== rtl/apbt_pkg.sv =====
// Package with the shared word types, lane control and register codes of the point and box transform.
`timescale 1ns / 1ps
`default_nettype none
package apbt_pkg;

	typedef logic signed [31:0] fix_t;
	typedef logic signed [47:0] ofs_t;

	localparam int NUM_AXES = 3;
	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] MODE_POINT  = 2'd0;
	localparam logic [1:0] MODE_DIR    = 2'd1;
	localparam logic [1:0] MODE_BOX    = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_XX_XY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_XZ_YX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YY_YZ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZX_ZY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZZ_OX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OY_OZ   = 3'd5;

	localparam logic [63:0] REG_ONE_RESET  = 64'h0001_0000_0000_0000;
	localparam logic [63:0] REG_ZERO_RESET = 64'h0;

	typedef struct packed {
		logic [1:0]  mode;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] upper_x;
		logic signed [31:0] upper_y;
		logic signed [31:0] upper_z;
	} out_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_ctl_t;

	typedef struct packed {
		fix_t lo;
		fix_t hi;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/apbt_lane.sv =====
// One axis lane: six multipliers, corner selection, summation and rounding with saturation.
`timescale 1ns / 1ps
`default_nettype none
module apbt_lane (
	input  wire logic               clk,
	input  wire apbt_pkg::pipe_ctl_t en,
	input  wire apbt_pkg::fix_t     a [3],
	input  wire apbt_pkg::fix_t     b [3],
	input  wire apbt_pkg::fix_t     k [3],
	input  wire apbt_pkg::ofs_t     t_lo,
	input  wire apbt_pkg::ofs_t     t_hi,
	input  wire logic               box,
	output apbt_pkg::lane_res_t     res
);
	import apbt_pkg::*;

	fix_t a_s1 [3];
	fix_t b_s1 [3];
	fix_t k_s1 [3];
	ofs_t tlo_s1, thi_s1, tlo_s2, thi_s2;
	logic box_s1, box_s2, box_s3, box_s4;
	logic signed [63:0] pa_s2 [3];
	logic signed [63:0] pb_s2 [3];
	logic signed [63:0] lo_t [3];
	logic signed [63:0] hi_t [3];
	logic signed [65:0] lo01_s3, lo2t_s3, hi01_s3, hi2t_s3;
	logic signed [65:0] lo_s4, hi_s4;

	function automatic fix_t reduce(input logic signed [65:0] s, input logic tz);
		logic signed [49:0] q;
		begin
			q = s[65:16];
			if (tz && s[65] && (s[15:0] != 16'd0))
				q = q + 50'sd1;
			if (q > 50'sd2147483647)
				return 32'sh7FFF_FFFF;
			if (q < -50'sd2147483648)
				return 32'sh8000_0000;
			return q[31:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int r = 0; r < 3; r++) begin
				a_s1[r] <= a[r];
				b_s1[r] <= b[r];
				k_s1[r] <= k[r];
			end
			tlo_s1 <= t_lo;
			thi_s1 <= t_hi;
			box_s1 <= box;
		end
		if (en.s2) begin
			for (int r = 0; r < 3; r++) begin
				pa_s2[r] <= a_s1[r] * k_s1[r];
				pb_s2[r] <= b_s1[r] * k_s1[r];
			end
			tlo_s2 <= tlo_s1;
			thi_s2 <= thi_s1;
			box_s2 <= box_s1;
		end
		if (en.s3) begin
			lo01_s3 <= 66'(lo_t[0]) + 66'(lo_t[1]);
			lo2t_s3 <= 66'(lo_t[2]) + 66'(tlo_s2);
			hi01_s3 <= 66'(hi_t[0]) + 66'(hi_t[1]);
			hi2t_s3 <= 66'(hi_t[2]) + 66'(thi_s2);
			box_s3  <= box_s2;
		end
		if (en.s4) begin
			lo_s4  <= lo01_s3 + lo2t_s3;
			hi_s4  <= hi01_s3 + hi2t_s3;
			box_s4 <= box_s3;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (box_s2) begin
				lo_t[r] = (pa_s2[r] < pb_s2[r]) ? pa_s2[r] : pb_s2[r];
				hi_t[r] = (pa_s2[r] < pb_s2[r]) ? pb_s2[r] : pa_s2[r];
			end else begin
				lo_t[r] = pa_s2[r];
				hi_t[r] = 64'sd0;
			end
		end
	end

	assign res.lo = reduce(lo_s4, box_s4);
	assign res.hi = reduce(hi_s4, box_s4);

endmodule
`default_nettype wire

// ===== rtl/apbt_merge.sv =====
// Output register that gathers the three lane results into one result word.
`timescale 1ns / 1ps
`default_nettype none
module apbt_merge (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire apbt_pkg::lane_res_t lane [3],
	output apbt_pkg::out_word_t      word
);
	import apbt_pkg::*;

	out_word_t word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.out_x   <= lane[0].lo;
			word_q.out_y   <= lane[1].lo;
			word_q.out_z   <= lane[2].lo;
			word_q.upper_x <= lane[0].hi;
			word_q.upper_y <= lane[1].hi;
			word_q.upper_z <= lane[2].hi;
		end
	end

	assign word = word_q;

endmodule
`default_nettype wire

// ===== rtl/affine_point_box_transform.sv =====
// Top level of the affine point, direction and box-bounds transform.
`timescale 1ns / 1ps
`default_nettype none
// The block accepts one word per cycle while in_stall is low and returns results in order;
// three axis lanes of six 32 by 32 multipliers each work side by side, and the box mode
// forms its bounds from per-term minimum and maximum products instead of visiting eight
// corners. A stall on the output holds every full stage; the input stalls only when all
// stages are full. The matrix registers are written through the configuration channel,
// which is always ready, and must be written only while no word is in flight.
module affine_point_box_transform (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire apbt_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output apbt_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data
);
	import apbt_pkg::*;

	logic [63:0] regs_q [NUM_REGS];
	fix_t m [3][3];
	fix_t tr [3];
	fix_t a [3];
	fix_t b [3];
	fix_t k [3][3];
	ofs_t tlo [3];
	ofs_t thi [3];
	logic box;
	logic v1_q, v2_q, v3_q, v4_q, ov_q;
	logic rdy_out, rdy1, rdy2, rdy3, rdy4;
	pipe_ctl_t ctl;
	lane_res_t res [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_XX_XY] <= REG_ONE_RESET;
			regs_q[REG_XZ_YX] <= REG_ZERO_RESET;
			regs_q[REG_YY_YZ] <= REG_ONE_RESET;
			regs_q[REG_ZX_ZY] <= REG_ZERO_RESET;
			regs_q[REG_ZZ_OX] <= REG_ONE_RESET;
			regs_q[REG_OY_OZ] <= REG_ZERO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_XX_XY: regs_q[REG_XX_XY] <= cfg_data;
				REG_XZ_YX: regs_q[REG_XZ_YX] <= cfg_data;
				REG_YY_YZ: regs_q[REG_YY_YZ] <= cfg_data;
				REG_ZX_ZY: regs_q[REG_ZX_ZY] <= cfg_data;
				REG_ZZ_OX: regs_q[REG_ZZ_OX] <= cfg_data;
				REG_OY_OZ: regs_q[REG_OY_OZ] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m[0][0] = regs_q[REG_XX_XY][63:32];
	assign m[0][1] = regs_q[REG_XX_XY][31:0];
	assign m[0][2] = regs_q[REG_XZ_YX][63:32];
	assign m[1][0] = regs_q[REG_XZ_YX][31:0];
	assign m[1][1] = regs_q[REG_YY_YZ][63:32];
	assign m[1][2] = regs_q[REG_YY_YZ][31:0];
	assign m[2][0] = regs_q[REG_ZX_ZY][63:32];
	assign m[2][1] = regs_q[REG_ZX_ZY][31:0];
	assign m[2][2] = regs_q[REG_ZZ_OX][63:32];
	assign tr[0]   = regs_q[REG_ZZ_OX][31:0];
	assign tr[1]   = regs_q[REG_OY_OZ][63:32];
	assign tr[2]   = regs_q[REG_OY_OZ][31:0];

	assign a[0] = in_word.first_x;
	assign a[1] = in_word.first_y;
	assign a[2] = in_word.first_z;
	assign b[0] = in_word.second_x;
	assign b[1] = in_word.second_y;
	assign b[2] = in_word.second_z;
	assign box  = (in_word.mode == MODE_BOX);

	// Lane c gathers column c of the basis, or row c for the transposed direction.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				case (in_word.mode)
					MODE_POINT, MODE_BOX: k[c][r] = m[r][c];
					MODE_DIR:             k[c][r] = m[c][r];
					default:              k[c][r] = 32'sd0;
				endcase
			end
			case (in_word.mode)
				MODE_POINT: begin
					tlo[c] = {tr[c], 16'd0};
					thi[c] = 48'sd0;
				end
				MODE_BOX: begin
					tlo[c] = 48'(tr[c]);
					thi[c] = 48'(tr[c]);
				end
				default: begin
					tlo[c] = 48'sd0;
					thi[c] = 48'sd0;
				end
			endcase
		end
	end

	assign rdy_out = !ov_q || !out_stall;
	assign rdy4    = !v4_q || rdy_out;
	assign rdy3    = !v3_q || rdy4;
	assign rdy2    = !v2_q || rdy3;
	assign rdy1    = !v1_q || rdy2;
	assign in_stall = !rdy1;

	assign ctl.s1 = rdy1;
	assign ctl.s2 = rdy2;
	assign ctl.s3 = rdy3;
	assign ctl.s4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= in_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy4)
				v4_q <= v3_q;
			if (rdy_out)
				ov_q <= v4_q;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		apbt_lane u_lane (
			.clk  (clk),
			.en   (ctl),
			.a    (a),
			.b    (b),
			.k    (k[c]),
			.t_lo (tlo[c]),
			.t_hi (thi[c]),
			.box  (box),
			.res  (res[c])
		);
	end

	apbt_merge u_merge (
		.clk  (clk),
		.load (rdy_out),
		.lane (res),
		.word (out_word)
	);

	assign out_valid = ov_q;

endmodule
`default_nettype wire
